// ===== src/cia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and codes of the cyclic identifier allocator.
// ----------------------------------------------------------------------------
package cia_pkg;

	localparam int WORD_W = 32;
	localparam int OFF_W  = 5;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_UNUSED = 2'd2;

	typedef struct packed {
		logic       op;
		logic [9:0] release_id;
	} req_t;

	typedef struct packed {
		logic [9:0] given_id;
		logic [1:0] status;
	} rsp_t;

endpackage

// ===== src/cia_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_ifs
// Request and response channels: valid, ready and one payload word.
// ----------------------------------------------------------------------------
interface cia_req_if;
	import cia_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cia_rsp_if;
	import cia_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/cia_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/cia_ffs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_ffs
// Lowest set bit of one map word: found flag and bit offset.
// ----------------------------------------------------------------------------
module cia_ffs (
	input  logic [cia_pkg::WORD_W-1:0] vec,
	output logic                       found,
	output logic [cia_pkg::OFF_W-1:0]  idx
);
	import cia_pkg::*;

	always_comb begin
		idx = '0;
		// walk downwards so the lowest set bit wins
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (vec[b]) begin
				idx = OFF_W'(b);
			end
		end
		found = |vec;
	end

endmodule

// ===== src/cyclic_id_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_id_allocator
// Cyclic identifier allocator over an in-use bitmap held in RAM words.
// ----------------------------------------------------------------------------
//  channel  dir  payload                         accepted when
//  req      in   op, release_id                  req.valid & req.ready
//  rsp      out  given_id, status                rsp.valid & rsp.ready
//
//  Release: read in the acceptance cycle, then update, then hand over to the
//  response register. Allocate scans the bitmap words in turn (the start word
//  twice when the search wraps) over NW = ceil(ID_SPACE/32) words, through
//  the single RAM read port. A release of identifier zero or past the space,
//  and an allocate refused at the live limit, skip the RAM.
//  After reset a clearing pass writes zero to all NW words, and req.ready
//  stays low until it ends. One request is in work at a time; a finished
//  response waits in its holding register while rsp is stalled.
// ----------------------------------------------------------------------------
module cyclic_id_allocator #(
	parameter int ID_SPACE = 1024,
	parameter int MAX_LIVE = 512
) (
	input  logic clk,
	input  logic arst_n,
	cia_req_if.sink   req,
	cia_rsp_if.source rsp
);
	import cia_pkg::*;

	localparam int NW = (ID_SPACE + WORD_W - 1) / WORD_W;
	localparam int AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int FW = AW + OFF_W;
	localparam int CW = $clog2(MAX_LIVE + 1);
	localparam int VW = $clog2(NW + 1);

	localparam logic [AW-1:0]     LAST_WORD  = AW'(NW - 1);
	localparam logic [WORD_W-1:0] TAIL_VALID = {WORD_W{1'b1}} >> (NW * WORD_W - ID_SPACE);
	localparam logic [FW:0]       ID_END     = (FW + 1)'(ID_SPACE);
	localparam logic [CW-1:0]     LIVE_MAX   = CW'(MAX_LIVE);
	localparam logic [VW-1:0]     VISIT_END  = VW'(NW);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_REL   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]        state_q;
	logic [FW-1:0]     last_q;
	logic [CW-1:0]     live_q;
	logic [AW-1:0]     word_q;
	logic [OFF_W-1:0]  off_q;
	logic              first_q;
	logic [VW-1:0]     visit_q;
	logic [AW-1:0]     clr_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;

	logic              accept;
	logic              is_full;
	logic [FW:0]       nxt_sum;
	logic [FW-1:0]     cand;
	logic              rel_bad;
	logic [FW-1:0]     rel_full;
	logic [AW-1:0]     word_nx;
	logic [WORD_W-1:0] exist;
	logic [WORD_W-1:0] start_mask;
	logic [WORD_W-1:0] free_vec;
	logic              free_found;
	logic [OFF_W-1:0]  free_off;
	logic [WORD_W-1:0] rel_bit;
	logic              slot_free;

	cia_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NW)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cia_ffs u_ffs (
		.vec   (free_vec),
		.found (free_found),
		.idx   (free_off)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign slot_free = !out_valid_q || rsp.ready;

	assign is_full  = (live_q >= LIVE_MAX);
	assign nxt_sum  = {1'b0, last_q} + (FW + 1)'(1);
	assign cand     = (nxt_sum >= ID_END) ? FW'(1) : nxt_sum[FW-1:0];
	assign rel_bad  = (req.data.release_id == 10'd0)
		|| ({22'd0, req.data.release_id} >= 32'(ID_SPACE));
	assign rel_full = FW'(req.data.release_id);
	assign word_nx  = (word_q == LAST_WORD) ? '0 : word_q + AW'(1);
	assign rel_bit  = WORD_W'(1) << off_q;

	// mask out identifiers past the top of the space, identifier zero and, on the start word, bits below the start offset
	always_comb begin
		exist = {WORD_W{1'b1}};
		if (word_q == LAST_WORD) begin
			exist = exist & TAIL_VALID;
		end
		if (word_q == '0) begin
			exist[0] = 1'b0;
		end
		start_mask = first_q ? ({WORD_W{1'b1}} << off_q) : {WORD_W{1'b1}};
		free_vec   = ~rd_data & exist & start_mask;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = word_nx;
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = rd_data;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE: begin
				if (req.data.op == OP_ALLOC) begin
					rd_en   = accept && !is_full;
					rd_addr = cand[FW-1:OFF_W];
				end else begin
					rd_en   = accept && !rel_bad;
					rd_addr = rel_full[FW-1:OFF_W];
				end
			end
			S_SCAN: begin
				// fetch the following word ahead; dropped once a free bit turns up
				rd_en   = !free_found;
				wr_en   = free_found;
				wr_data = rd_data | (WORD_W'(1) << free_off);
			end
			S_REL: begin
				wr_en   = |(rd_data & rel_bit);
				wr_data = rd_data & ~rel_bit;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			last_q      <= FW'(ID_SPACE - 1);
			live_q      <= '0;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
			visit_q     <= '0;
		end else begin
			// hand over once the response register is free
			if (state_q == S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_q.given_id <= '0;
						first_q        <= 1'b1;
						visit_q        <= '0;
						if (req.data.op == OP_ALLOC) begin
							word_q <= cand[FW-1:OFF_W];
							off_q  <= cand[OFF_W-1:0];
							if (is_full) begin
								res_q.status <= STATUS_FULL;
								state_q      <= S_FIN;
							end else begin
								res_q.status <= STATUS_OK;
								state_q      <= S_SCAN;
							end
						end else begin
							word_q <= rel_full[FW-1:OFF_W];
							off_q  <= rel_full[OFF_W-1:0];
							if (rel_bad) begin
								res_q.status <= STATUS_UNUSED;
								state_q      <= S_FIN;
							end else begin
								res_q.status <= STATUS_OK;
								state_q      <= S_REL;
							end
						end
					end
				end
				S_SCAN: begin
					if (free_found) begin
						last_q         <= {word_q, free_off};
						live_q         <= live_q + CW'(1);
						res_q.given_id <= 10'({word_q, free_off});
						state_q        <= S_FIN;
					end else if (visit_q == VISIT_END) begin
						res_q.status <= STATUS_FULL;
						state_q      <= S_FIN;
					end else begin
						word_q  <= word_nx;
						first_q <= 1'b0;
						visit_q <= visit_q + VW'(1);
					end
				end
				S_REL: begin
					if (|(rd_data & rel_bit)) begin
						if (live_q != '0) begin
							live_q <= live_q - CW'(1);
						end
					end else begin
						res_q.status <= STATUS_UNUSED;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && slot_free) begin
			out_q <= res_q;
		end
	end

endmodule
